// File: rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg
// shared constants and types of the bounding box diagonal unit
// ----------------------------------------------------------------------------
package bbd_pkg;

   // default coordinate width, 16 fraction bits
   localparam int COORD_BITS_DFLT = 24;

   // result field and its padded bus
   localparam int DIAG_BITS     = 25;
   localparam int RSP_DATA_BITS = 32;

   // number of axes
   localparam int AXES = 3;

   // root unit control, top to root unit
   typedef struct packed {
      logic start;
   } sqrt_ctrl_type;

   // root unit status, root unit to top
   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

endpackage

// File: rtl/bounding_box_diagonal_unit.sv
// ----------------------------------------------------------------------------
// bounding_box_diagonal_unit
// axis-aligned bounding box diagonal of a stream of 3-d points
// ----------------------------------------------------------------------------
// Points arrive one per transfer as signed fixed-point x, y, z (COORD_BITS
// each, 16 fraction bits). The first point of a set loads the per-axis
// minimum and maximum, later points widen them; a point without tlast leaves
// req_tready high, so the next can follow right behind it. The point with
// tlast closes the set: the three spans are squared one after another on a
// single shared multiplier (per axis the steps span, square, accumulate),
// then an iterative square root retires one root bit per cycle. A closing
// point therefore keeps req_tready low through these steps, the root start,
// the COORD_BITS + 1 root iterations and the output step. The result is
// floor(sqrt(span_x^2 + span_y^2 + span_z^2)) with 16 fraction bits,
// saturated to 25 bits, held in an output register until taken; a
// one-point set gives zero. The set state clears after each closing point.
// ----------------------------------------------------------------------------
module bounding_box_diagonal_unit #(
   parameter  int COORD_BITS    = bbd_pkg::COORD_BITS_DFLT,
   localparam int REQ_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // point channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_DATA_BITS-1:0]          req_tdata,   // coord_x, coord_y, coord_z
   input  logic                              req_tlast,   // last_point
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bbd_pkg::RSP_DATA_BITS-1:0] rsp_tdata    // diagonal
);
   import bbd_pkg::*;

   localparam int ROOT_BITS = COORD_BITS + 1;
   localparam int SUM_BITS  = 2 * ROOT_BITS;
   localparam int PROD_BITS = 2 * COORD_BITS;
   localparam int AXIS_BITS = $clog2(AXES);

   // sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SPAN  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_START = 3'd4;
   localparam logic [2:0] ST_ROOT  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [AXIS_BITS-1:0]         axis_ff, axis_in;
   logic                         started_ff, started_in;

   // running box, one entry per axis
   logic signed [COORD_BITS-1:0] low_ff  [AXES];
   logic signed [COORD_BITS-1:0] high_ff [AXES];
   logic signed [COORD_BITS-1:0] coord_w [AXES];

   // shared multiply path
   logic [COORD_BITS-1:0]        span_ff;
   logic [COORD_BITS-1:0]        span_w;
   logic [PROD_BITS-1:0]         prod_ff;
   logic [SUM_BITS-1:0]          acc_ff, acc_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DIAG_BITS-1:0]         diag_ff;
   logic [DIAG_BITS-1:0]         diag_w;

   sqrt_ctrl_type                sq_ctrl;
   sqrt_stat_type                sq_stat;
   logic [ROOT_BITS-1:0]         sq_root;

   logic                         req_xfer;
   logic                         out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // unpack coordinates, x in the low bits
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         coord_w[a] = req_tdata[a*COORD_BITS +: COORD_BITS];
      end
   end

   // span of the selected axis, never negative and below 2^COORD_BITS
   assign span_w = COORD_BITS'(high_ff[axis_ff]) - COORD_BITS'(low_ff[axis_ff]);

   // min / max update on every accepted point
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int a = 0; a < AXES; a++) begin
            if (!started_ff) begin
               low_ff[a]  <= coord_w[a];
               high_ff[a] <= coord_w[a];
            end else begin
               if (coord_w[a] > high_ff[a]) high_ff[a] <= coord_w[a];
               if (coord_w[a] < low_ff[a])  low_ff[a]  <= coord_w[a];
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      started_in = started_ff;
      acc_in     = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               started_in = !req_tlast;
               if (req_tlast) begin
                  state_in = ST_SPAN;
                  axis_in  = '0;
                  acc_in   = '0;
               end
            end
         end
         ST_SPAN:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_ACC;
         ST_ACC: begin
            acc_in = acc_ff + SUM_BITS'(prod_ff);
            if (axis_ff == AXIS_BITS'(AXES - 1)) begin
               state_in = ST_START;
            end else begin
               axis_in  = axis_ff + AXIS_BITS'(1);
               state_in = ST_SPAN;
            end
         end
         ST_START: state_in = ST_ROOT;
         ST_ROOT: begin
            if (sq_stat.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   assign sq_ctrl.start = (state_ff == ST_START);

   bbd_isqrt #(
      .ROOT_BITS (ROOT_BITS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sq_ctrl),
      .radicand (acc_ff),
      .stat     (sq_stat),
      .root     (sq_root)
   );

   // clamp to the 25-bit result field at wide coordinates
   generate
      if (ROOT_BITS > DIAG_BITS) begin : g_sat
         assign diag_w = (|sq_root[ROOT_BITS-1:DIAG_BITS]) ? '1
                                                           : sq_root[DIAG_BITS-1:0];
      end else begin : g_nosat
         assign diag_w = DIAG_BITS'(sq_root);
      end
   endgenerate

   // output register, refilled only once the previous result is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SPAN) span_ff <= span_w;
      if (state_ff == ST_MUL)  prod_ff <= span_ff * span_ff;
      acc_ff <= acc_in;
      if (state_ff == ST_OUT && out_free) diag_ff <= diag_w;
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(diag_ff);

`ifndef NO_ASSERTIONS
   // root unit is never restarted while it still works
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      sq_ctrl.start |-> !sq_stat.busy)
      else $error("root unit started while busy");

   // a closing point blocks the channel on the next cycle
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> !req_tready)
      else $error("point accepted during diagonal computation");

   // a new result appears only from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_OUT))
      else $error("result appeared outside the output step");

   // a result waiting in the output register is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(diag_ff))
      else $error("pending result overwritten");
`endif

endmodule

// File: rtl/bbd_isqrt.sv
// ----------------------------------------------------------------------------
// bbd_isqrt
// iterative floor square root, one root bit per cycle
// ----------------------------------------------------------------------------
module bbd_isqrt #(
   parameter int ROOT_BITS = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bbd_pkg::sqrt_ctrl_type      ctrl,
   input  logic [2*ROOT_BITS-1:0]      radicand,
   output bbd_pkg::sqrt_stat_type      stat,
   output logic [ROOT_BITS-1:0]        root
);
   import bbd_pkg::*;

   localparam int RAD_BITS = 2 * ROOT_BITS;
   localparam int REM_BITS = ROOT_BITS + 3;
   localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

   logic [RAD_BITS-1:0]  rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [REM_BITS-1:0]  rem_sh;
   logic [REM_BITS-1:0]  trial;

   // bring down the next pair of radicand bits, try root*4+1
   assign rem_sh = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial  = REM_BITS'({root_ff, 2'b01});

   always_comb begin
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
         count_in = CNT_BITS'(ROOT_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule

// File: bench/bounding_box_diagonal_unit_tb.sv
// ----------------------------------------------------------------------------
// bounding_box_diagonal_unit_tb
// self-checking bench for the bounding box diagonal unit
// ----------------------------------------------------------------------------
// Sends sets of 3-d points into the point channel and keeps its own running
// box per set. On each closing point it works out floor(sqrt(sum of squared
// spans)) and holds the value until the result channel hands a diagonal
// back. Directed sets cover one-point sets, the coordinate extremes and the
// largest diagonal. Random sets mix full-range and tight boxes with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bounding_box_diagonal_unit_tb;

   localparam int COORD_BITS  = bbd_pkg::COORD_BITS_DFLT;
   localparam int DIAG_BITS   = bbd_pkg::DIAG_BITS;
   localparam int RSP_BITS    = bbd_pkg::RSP_DATA_BITS;
   localparam int REQ_BITS    = ((3 * COORD_BITS + 7) / 8) * 8;
   localparam int POINT_GOAL  = 1450;
   localparam int CYCLE_LIMIT = 600000;
   // drain margin, longer than a closing point holds the channel
   localparam int TAIL_CYCLES = 3 * COORD_BITS;
   localparam int MAX_GAP     = 13;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [DIAG_BITS-1:0]         DIAG_SAT  = '1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DIAG_BITS-1:0]         diag_type;

   // one point as queued for the point channel
   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
      bit        hold;      // wait for every pending diagonal before sending
   } point_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata  = '0;   // coord_x, coord_y, coord_z
   logic                req_tlast  = 1'b0; // last_point
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;         // diagonal

   bounding_box_diagonal_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // box tracker: running per-axis bounds of the open set
   // ------------------------------------------------------------------------
   coord_type box_lo [3];
   coord_type box_hi [3];
   bit        box_open = 1'b0;

   // diagonals owed by the unit, indexed by closing order
   diag_type diag_owed [int];
   int       diag_due  = 0;      // closing points accepted (nonblocking)
   int       diag_seen = 0;      // diagonals taken off the result channel (nonblocking)

   point_type point_q [$];
   int        mismatches = 0;
   int        stray_results = 0;
   int        points_sent = 0;
   int        hold_count = 0;
   int        cycle_count = 0;

   // floor square root of a 68-bit value, two bits per step
   function automatic logic [33:0] floor_root(input logic [67:0] v);
      logic [71:0] rem;
      logic [71:0] trial;
      logic [33:0] root;
      rem  = '0;
      root = '0;
      for (int k = 33; k >= 0; k--) begin
         rem   = (rem << 2) | 72'(v[2*k +: 2]);
         trial = (72'(root) << 2) | 72'd1;
         root  = root << 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = root | 34'd1;
         end
      end
      return root;
   endfunction

   // folds one point into the box; returns 1 with the diagonal on a closing point
   function automatic bit absorb_point(input point_type p, output diag_type diag);
      coord_type   c [3];
      longint      span;
      logic [67:0] sum;
      logic [33:0] root;
      c[0] = p.x;
      c[1] = p.y;
      c[2] = p.z;
      diag = '0;
      for (int a = 0; a < 3; a++) begin
         if (!box_open) begin
            box_lo[a] = c[a];
            box_hi[a] = c[a];
         end else begin
            if (c[a] > box_hi[a]) box_hi[a] = c[a];
            if (c[a] < box_lo[a]) box_lo[a] = c[a];
         end
      end
      box_open = 1'b1;
      if (!p.last) return 1'b0;
      sum = '0;
      for (int a = 0; a < 3; a++) begin
         span = longint'(box_hi[a]) - longint'(box_lo[a]);
         sum  = sum + 68'(span) * 68'(span);
      end
      root = floor_root(sum);
      diag = (root > 34'(DIAG_SAT)) ? DIAG_SAT : root[DIAG_BITS-1:0];
      for (int a = 0; a < 3; a++) begin
         box_lo[a] = '0;
         box_hi[a] = '0;
      end
      box_open = 1'b0;
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // point driver
   // ------------------------------------------------------------------------
   point_type pt_cur;
   int        pt_gap = 0;
   int        pt_calm = 0;   // points left in a run with no gaps

   always @(posedge clock) begin
      bit       fire;
      bit       closing;
      bit       pending;
      diag_type diag;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
      end else begin
         fire    = req_tvalid && req_tready;
         closing = 1'b0;
         if (fire) begin
            points_sent++;
            closing = absorb_point(pt_cur, diag);
            if (closing) begin
               diag_owed[diag_due] = diag;
               diag_due <= diag_due + 1;
            end
         end
         if (!req_tvalid || fire) begin
            // a closing point accepted on this edge is not yet in diag_due
            pending = (diag_due != diag_seen) || closing;
            if (pt_gap > 0) begin
               pt_gap--;
               req_tvalid <= 1'b0;
            end else if (point_q.size() > 0 && !(point_q[0].hold && pending)) begin
               pt_cur = point_q.pop_front();
               if (pt_cur.hold) hold_count++;
               req_tdata  <= REQ_BITS'({pt_cur.z, pt_cur.y, pt_cur.x});
               req_tlast  <= pt_cur.last;
               req_tvalid <= 1'b1;
               // gap before the next point
               if (pt_calm > 0) begin
                  pt_calm--;
                  pt_gap = 0;
               end else begin
                  pt_gap = $urandom_range(0, MAX_GAP);
                  if ($urandom_range(0, 49) == 0) pt_calm = $urandom_range(10, 60);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result monitor and checker
   // ------------------------------------------------------------------------
   int rs_stall = 0;
   int rs_calm = 0;   // results left in a run with no stalls

   always @(posedge clock) begin
      diag_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (diag_seen >= diag_due) begin
               $error("diagonal transfer with nothing pending: actual %0d",
                      rsp_tdata[DIAG_BITS-1:0]);
               mismatches++;
               stray_results++;
            end else begin
               want = diag_owed[diag_seen];
               diag_owed.delete(diag_seen);
               if (rsp_tdata[DIAG_BITS-1:0] !== want) begin
                  $error("diagonal mismatch: expected %0d actual %0d",
                         want, rsp_tdata[DIAG_BITS-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[RSP_BITS-1:DIAG_BITS] !== '0) begin
                  $error("padding mismatch: expected 0 actual %0h",
                         rsp_tdata[RSP_BITS-1:DIAG_BITS]);
                  mismatches++;
               end
               diag_seen <= diag_seen + 1;
            end
            // stall before the next result
            if (rs_calm > 0) begin
               rs_calm--;
               rs_stall = 0;
            end else begin
               rs_stall = $urandom_range(0, MAX_GAP);
               if ($urandom_range(0, 19) == 0) rs_calm = $urandom_range(5, 30);
            end
         end
         if (rs_stall > 0) begin
            rs_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL bounding_box_diagonal_unit");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic add_point(input coord_type x, input coord_type y, input coord_type z,
                            input logic last, input bit hold = 1'b0);
      point_type p;
      p.x    = x;
      p.y    = y;
      p.z    = z;
      p.last = last;
      p.hold = hold;
      point_q = {point_q, p};
   endtask

   // coordinate within reach of a center, clipped to the coordinate range
   function automatic coord_type near_coord(input int center, input int reach);
      int v;
      if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      v = center + int'($urandom_range(0, 2 * reach)) - reach;
      if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
      if (v < int'(COORD_MIN)) v = int'(COORD_MIN);
      return v[COORD_BITS-1:0];
   endfunction

   initial begin
      int set_len;
      int reach;
      int cx;
      int cy;
      int cz;
      int set_count;
      int point_total;

      // directed: one-point sets give zero
      add_point('0, '0, '0, 1'b1);
      add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      add_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
      // opposite corners give the largest diagonal
      add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
      add_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
      // full span on one axis, given high then low
      add_point(COORD_MAX, '0, '0, 1'b0);
      add_point(COORD_MIN, '0, '0, 1'b1);
      // repeated point, nothing widens
      add_point(24'sd1, 24'sd1, 24'sd1, 1'b0);
      add_point(24'sd1, 24'sd1, 24'sd1, 1'b0);
      add_point(24'sd1, 24'sd1, 24'sd1, 1'b1);
      // widen low and high on every axis, closing point inside the box
      add_point('0, '0, '0, 1'b0);
      add_point(-24'sd5, 24'sd7, -24'sd3, 1'b0);
      add_point(24'sd10, -24'sd2, 24'sd4, 1'b0);
      add_point(24'sd3, 24'sd3, 24'sd3, 1'b1);
      // smallest nonzero span
      add_point('0, '0, '0, 1'b0);
      add_point('0, '0, 24'sd1, 1'b1);
      // alternating bit patterns, and a pause until everything has drained
      add_point(24'sh555555, -24'sd1, 24'shAAAAAA, 1'b0, 1'b1);
      add_point(24'shAAAAAA, 24'sh555555, -24'sd1, 1'b1);

      // random sets: a center, a reach from tight to full range
      while (point_q.size() < POINT_GOAL) begin
         set_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 10);
         reach   = 1 << $urandom_range(0, 22);
         cx      = int'($urandom) >>> (32 - COORD_BITS);
         cy      = int'($urandom) >>> (32 - COORD_BITS);
         cz      = int'($urandom) >>> (32 - COORD_BITS);
         for (int i = 0; i < set_len; i++) begin
            add_point(near_coord(cx, reach), near_coord(cy, reach), near_coord(cz, reach),
                      i == set_len - 1, i == 0 && $urandom_range(0, 39) == 0);
         end
      end
      point_total = point_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // every point accepted, then every diagonal back
      do @(posedge clock); while (points_sent < point_total);
      @(posedge clock);
      while (diag_seen != diag_due) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (diag_seen != diag_due) begin
         $error("diagonals still pending at end: expected %0d actual %0d",
                diag_due, diag_seen);
         mismatches++;
      end
      set_count = diag_due;
      $display("run covered %0d points in %0d sets, %0d drain pauses, %0d stray results",
               points_sent, set_count, hold_count, stray_results);
      $display("diagonals checked: %0d, mismatches: %0d", diag_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS bounding_box_diagonal_unit");
      end else begin
         $display("FAIL bounding_box_diagonal_unit");
      end
      $finish;
   end

endmodule
